// ===== rtl/plqt_pkg.sv =====
package plqt_pkg;

    // Message and id geometry
    localparam int ACC_W         = 3;
    localparam int NUM_ACCEPTORS = 1 << ACC_W;
    localparam int ROUND_W       = 32;
    localparam int UID_W         = 8;
    localparam int ID_W          = ROUND_W + UID_W;
    localparam int VALUE_BITS    = 32;

    // Per-proposal counters saturate at all ones
    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration registers
    localparam int QUORUM_W   = 4;
    localparam int NODE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_QUORUM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID = 2'd1;

    localparam logic [QUORUM_W-1:0] QUORUM_RESET  = 4'd5;
    localparam logic [NODE_W-1:0]   NODE_ID_RESET = 8'd0;

    typedef struct packed {
        logic [ACC_W-1:0]      acceptor_index;
        logic [ROUND_W-1:0]    proposal_round;
        logic [UID_W-1:0]      proposer_uid;
        logic [VALUE_BITS-1:0] value_tag;
    } plqt_msg_t;

    typedef struct packed {
        logic [NODE_W-1:0]     sender_id;
        logic [VALUE_BITS-1:0] resolved_value;
        logic                  early;
    } plqt_res_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } plqt_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic emit;
        logic out_blocked;
    } plqt_stat_t;

endpackage

// ===== rtl/plqt_if.sv =====
interface plqt_msg_if import plqt_pkg::*;;
    logic      valid;
    logic      ready;
    plqt_msg_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface plqt_res_if import plqt_pkg::*;;
    logic      valid;
    logic      ready;
    plqt_res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface plqt_cfg_if import plqt_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/plqt_ctrl.sv =====
module plqt_ctrl import plqt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    output logic       msg_ready,
    input  plqt_stat_t stat,
    output plqt_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       commit;
    logic       capture;

    // Update waits only when it has a result and the output register is still full
    assign commit    = (state_reg == S_UPD) && !(stat.emit && stat.out_blocked);
    assign msg_ready = (state_reg == S_IDLE) || commit;
    assign capture   = msg_valid && msg_ready;

    assign cmd.capture = capture;
    assign cmd.lookup  = (state_reg == S_LOOK);
    assign cmd.commit  = commit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (capture)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (commit)
                    state_next = capture ? S_LOOK : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_capture_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> state_reg == S_LOOK)
        else $error("captured request did not move to lookup");

    a_stall_holds_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && !commit) |=> state_reg == S_UPD)
        else $error("update left without commit");

endmodule

// ===== rtl/plqt_datapath.sv =====
module plqt_datapath import plqt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  plqt_msg_t             msg_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  plqt_cmd_t             cmd,
    output plqt_stat_t            stat,
    input  logic                  res_ready,
    output logic                  res_valid,
    output plqt_res_t             res_data
);

    // Captured request
    logic [ACC_W-1:0]      acc_reg;
    logic [ID_W-1:0]       id_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // Lookup results
    logic                     early_reg;
    logic                     stale_reg;
    logic [NUM_ACCEPTORS-1:0] old_hit_reg;
    logic [NUM_ACCEPTORS-1:0] new_hit_reg;

    // Tables
    logic [NUM_ACCEPTORS-1:0] al_valid_reg;
    logic [ID_W-1:0]          al_id_reg [NUM_ACCEPTORS];
    logic [NUM_ACCEPTORS-1:0] pid_valid_reg;
    logic [ID_W-1:0]          pid_reg   [NUM_ACCEPTORS];
    logic [CNT_W-1:0]         pacc_reg  [NUM_ACCEPTORS];
    logic [CNT_W-1:0]         pret_reg  [NUM_ACCEPTORS];

    logic                  final_valid_reg;
    logic [ID_W-1:0]       final_id_reg;
    logic [VALUE_BITS-1:0] final_value_reg;

    logic [QUORUM_W-1:0] quorum_reg;
    logic [NODE_W-1:0]   node_reg;

    logic      out_valid_reg;
    plqt_res_t out_data_reg;

    // Lookup stage
    logic                     had_last;
    logic [ID_W-1:0]          last_id;
    logic                     early_c;
    logic                     stale_c;
    logic [NUM_ACCEPTORS-1:0] old_hit_c;
    logic [NUM_ACCEPTORS-1:0] new_hit_c;

    // Update stage
    logic [CNT_W-1:0]         ret_dec [NUM_ACCEPTORS];
    logic [CNT_W-1:0]         acc_inc [NUM_ACCEPTORS];
    logic [CNT_W-1:0]         ret_inc [NUM_ACCEPTORS];
    logic [NUM_ACCEPTORS-1:0] live;
    logic [NUM_ACCEPTORS-1:0] free_sel;
    logic [NUM_ACCEPTORS-1:0] sel;
    logic [NUM_ACCEPTORS-1:0] hit_q;
    logic                     found;
    logic                     decide;
    logic                     emit;
    logic                     apply;

    assign had_last = al_valid_reg[acc_reg];
    assign last_id  = al_id_reg[acc_reg];
    assign early_c  = final_valid_reg && (id_reg >= final_id_reg)
                      && (val_reg == final_value_reg);
    assign stale_c  = had_last && (id_reg <= last_id);

    always_comb
    begin
        for (int i = 0; i < NUM_ACCEPTORS; i++)
        begin
            old_hit_c[i] = had_last && pid_valid_reg[i] && (pid_reg[i] == last_id);
            new_hit_c[i] = pid_valid_reg[i] && (pid_reg[i] == id_reg);
        end
    end

    // Release the acceptor's previous proposal, then pick the matching or first free entry
    always_comb
    begin
        logic [CNT_W-1:0] base_acc;
        logic [CNT_W-1:0] base_ret;
        for (int i = 0; i < NUM_ACCEPTORS; i++)
        begin
            ret_dec[i] = (pret_reg[i] != '0) ? pret_reg[i] - 1'b1 : '0;
            live[i]    = pid_valid_reg[i] && !(old_hit_reg[i] && ret_dec[i] == '0);
        end
        found    = |new_hit_reg;
        free_sel = ~live & (live + 1'b1);
        sel      = found ? new_hit_reg : free_sel;
        for (int i = 0; i < NUM_ACCEPTORS; i++)
        begin
            base_acc   = found ? pacc_reg[i] : '0;
            base_ret   = found ? pret_reg[i] : '0;
            acc_inc[i] = (base_acc == CNT_MAX) ? base_acc : base_acc + 1'b1;
            ret_inc[i] = (base_ret == CNT_MAX) ? base_ret : base_ret + 1'b1;
            hit_q[i]   = sel[i] && (acc_inc[i] == {{(CNT_W-QUORUM_W){1'b0}}, quorum_reg});
        end
    end

    assign decide = |hit_q;
    assign emit   = early_reg || (!stale_reg && decide);
    assign apply  = cmd.commit && !early_reg && !stale_reg;

    assign stat.emit        = emit;
    assign stat.out_blocked = out_valid_reg && !res_ready;

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            acc_reg <= msg_data.acceptor_index;
            id_reg  <= {msg_data.proposal_round, msg_data.proposer_uid};
            val_reg <= msg_data.value_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            early_reg   <= 1'b0;
            stale_reg   <= 1'b0;
            old_hit_reg <= '0;
            new_hit_reg <= '0;
        end
        else if (cmd.lookup)
        begin
            early_reg   <= early_c;
            stale_reg   <= stale_c;
            old_hit_reg <= old_hit_c;
            new_hit_reg <= new_hit_c;
        end
    end

    // Valid bits and decision state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            al_valid_reg    <= '0;
            pid_valid_reg   <= '0;
            final_valid_reg <= 1'b0;
            final_id_reg    <= '0;
            final_value_reg <= '0;
        end
        else if (apply)
        begin
            if (decide)
            begin
                al_valid_reg    <= '0;
                pid_valid_reg   <= '0;
                final_valid_reg <= 1'b1;
                final_id_reg    <= id_reg;
                final_value_reg <= val_reg;
            end
            else
            begin
                al_valid_reg[acc_reg] <= 1'b1;
                pid_valid_reg         <= live | sel;
            end
        end
    end

    // Table payload
    always_ff @(posedge clk)
    begin
        if (apply && !decide)
        begin
            al_id_reg[acc_reg] <= id_reg;
            for (int i = 0; i < NUM_ACCEPTORS; i++)
            begin
                if (old_hit_reg[i])
                    pret_reg[i] <= ret_dec[i];
                if (sel[i])
                begin
                    pacc_reg[i] <= acc_inc[i];
                    pret_reg[i] <= ret_inc[i];
                    if (!found)
                        pid_reg[i] <= id_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quorum_reg <= QUORUM_RESET;
            node_reg   <= NODE_ID_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_QUORUM)
                quorum_reg <= cfg_data[QUORUM_W-1:0];
            if (cfg_index == REG_NODE_ID)
                node_reg <= cfg_data[NODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit && emit)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && emit)
        begin
            out_data_reg.sender_id      <= node_reg;
            out_data_reg.resolved_value <= early_reg ? final_value_reg : val_reg;
            out_data_reg.early          <= early_reg;
        end
    end

    a_decide_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (apply && decide) |=> (al_valid_reg == '0) && (pid_valid_reg == '0))
        else $error("tables not cleared after decision");

    a_result_needs_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> final_valid_reg)
        else $error("result without a decided value");

    a_single_entry: assert property (@(posedge clk) disable iff (!rst_n)
        apply |-> $onehot0(sel) && ((old_hit_reg & new_hit_reg) == '0))
        else $error("update selects more than one entry");

endmodule

// ===== rtl/paxos_learner_quorum_tracker.sv =====
// Paxos learner quorum tracker. Each request on msg is one "accepted" message
// (acceptor index, proposal round/proposer uid, value tag). The block tracks
// every acceptor's newest proposal id and a small table of live proposals with
// accept and retain counts; when one proposal's accept count equals the
// quorum threshold the value is decided, the tables are cleared and a
// resolution (early = 0) goes out on res. A later message carrying the decided
// value with an id no lower than the decided id yields an early resolution
// (early = 1) and changes nothing else. Stale messages produce no result. A
// message passes through a lookup state, which looks the request up in the
// acceptor and proposal tables, and an update state, which applies the
// read-modify-write of counts and valid bits; the next message is taken in
// the update state. A message that resolves while the previous resolution
// still sits unread in the output register holds in the update state until
// res is ready. cfg writes (index 0 quorum threshold, index 1 node_id) are
// always taken and belong to idle periods.
module paxos_learner_quorum_tracker import plqt_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    plqt_msg_if.sink      msg,
    plqt_res_if.source    res,
    plqt_cfg_if.sink      cfg
);

    plqt_cmd_t  cmd;
    plqt_stat_t stat;

    // Config port never back-pressures
    assign cfg.ready = 1'b1;

    // Sequencer: idle / lookup / update
    plqt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg.valid),
        .msg_ready (msg.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Tables, decision state, config and output register
    plqt_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_data  (msg.payload),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .stat      (stat),
        .res_ready (res.ready),
        .res_valid (res.valid),
        .res_data  (res.payload)
    );

endmodule

// ===== verif/tb_paxos_learner_quorum_tracker.sv =====
`timescale 1ns / 100ps

module tb_paxos_learner_quorum_tracker import plqt_pkg::*;;

    // ------------------------------------------------------------------
    // Resolution predictor and scoreboard.
    // Tracks acceptor history, live proposals and the decided value,
    // queues the resolution each accepted message should produce and
    // checks the block's resolutions against that queue in order.
    // ------------------------------------------------------------------
    class quorum_scoreboard;
        bit [QUORUM_W-1:0]   quorum;
        bit [NODE_W-1:0]     node;
        // newest id seen per acceptor
        bit                  heard    [NUM_ACCEPTORS];
        bit [ID_W-1:0]       heard_id [NUM_ACCEPTORS];
        // live proposals; stored value never reaches the output, so not kept
        bit                  live     [NUM_ACCEPTORS];
        bit [ID_W-1:0]       live_id  [NUM_ACCEPTORS];
        bit [CNT_W-1:0]      accepts  [NUM_ACCEPTORS];
        bit [CNT_W-1:0]      retains  [NUM_ACCEPTORS];
        // last decision
        bit                  decided;
        bit [ID_W-1:0]       decided_id;
        bit [VALUE_BITS-1:0] decided_val;
        plqt_res_t           resolutions_due[$];
        int unsigned         failures;

        function new();
            quorum      = QUORUM_RESET;
            node        = NODE_ID_RESET;
            decided     = 1'b0;
            decided_id  = '0;
            decided_val = '0;
            failures    = 0;
            clear_tables();
        endfunction

        function void clear_tables();
            for (int i = 0; i < NUM_ACCEPTORS; i++)
            begin
                heard[i]    = 1'b0;
                heard_id[i] = '0;
                live[i]     = 1'b0;
                live_id[i]  = '0;
                accepts[i]  = '0;
                retains[i]  = '0;
            end
        endfunction

        function void set_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            if (idx == REG_QUORUM)
                quorum = data[QUORUM_W-1:0];
            else if (idx == REG_NODE_ID)
                node = data[NODE_W-1:0];
        endfunction

        function int find_live(bit [ID_W-1:0] key);
            for (int i = 0; i < NUM_ACCEPTORS; i++)
                if (live[i] && live_id[i] == key)
                    return i;
            return -1;
        endfunction

        function void note_request(plqt_msg_t m);
            int                  a;
            int                  e;
            bit [ID_W-1:0]       key;
            bit [VALUE_BITS-1:0] val;
            bit                  had;
            bit [ID_W-1:0]       prev;
            plqt_res_t           r;
            a   = m.acceptor_index;
            key = {m.proposal_round, m.proposer_uid};
            val = m.value_tag;

            // repeat of the decided value at or above the decided id
            if (decided && key >= decided_id && val == decided_val)
            begin
                r.sender_id      = node;
                r.resolved_value = decided_val;
                r.early          = 1'b1;
                resolutions_due.push_back(r);
                return;
            end

            had  = heard[a];
            prev = heard_id[a];
            if (had && key <= prev)
                return;
            heard[a]    = 1'b1;
            heard_id[a] = key;

            // acceptor drops its retain on the proposal it held before
            if (had)
            begin
                e = find_live(prev);
                if (e >= 0)
                begin
                    if (retains[e] != 0)
                        retains[e]--;
                    if (retains[e] == 0)
                        live[e] = 1'b0;
                end
            end

            e = find_live(key);
            if (e < 0)
            begin
                for (int i = 0; i < NUM_ACCEPTORS; i++)
                    if (!live[i] && e < 0)
                        e = i;
                if (e < 0)
                    return;
                live[e]    = 1'b1;
                live_id[e] = key;
                accepts[e] = '0;
                retains[e] = '0;
            end

            if (accepts[e] != CNT_MAX)
                accepts[e]++;
            if (retains[e] != CNT_MAX)
                retains[e]++;

            if (accepts[e] == CNT_W'(quorum))
            begin
                decided     = 1'b1;
                decided_id  = key;
                decided_val = val;
                clear_tables();
                r.sender_id      = node;
                r.resolved_value = val;
                r.early          = 1'b0;
                resolutions_due.push_back(r);
            end
        endfunction

        function void check_result(plqt_res_t got);
            plqt_res_t want;
            if (resolutions_due.size() == 0)
            begin
                $error("resolution with none pending: sender_id %0h value %0h early %0b",
                       got.sender_id, got.resolved_value, got.early);
                failures++;
                return;
            end
            want = resolutions_due.pop_front();
            if (want.sender_id !== got.sender_id)
            begin
                $error("sender_id: expected %0h, got %0h", want.sender_id, got.sender_id);
                failures++;
            end
            if (want.resolved_value !== got.resolved_value)
            begin
                $error("resolved_value: expected %0h, got %0h",
                       want.resolved_value, got.resolved_value);
                failures++;
            end
            if (want.early !== got.early)
            begin
                $error("early: expected %0b, got %0b", want.early, got.early);
                failures++;
            end
        endfunction

        function int outstanding();
            return resolutions_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #2 clk = ~clk;

    plqt_msg_if msg_if ();
    plqt_res_if res_if ();
    plqt_cfg_if cfg_if ();

    paxos_learner_quorum_tracker u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    quorum_scoreboard sb;

    // calm = 1: neither side idles, so back-to-back requests hit the block
    bit calm = 1'b0;

    // the ballot base never moves down, so ballot rounds climb over a phase
    bit [ROUND_W-1:0]    ballot_base;
    bit [VALUE_BITS-1:0] value_pool [4];

    // random phases: quorum setting and request count; 0 and 15 never decide
    int phase_quorum [10] = '{8, 1, 3, 0, 5, 15, 4, 6, 2, 7};
    int phase_items  [10] = '{300, 200, 250, 80, 250, 80, 200, 150, 150, 150};

    function automatic plqt_msg_t make_msg(bit [ACC_W-1:0] acc, bit [ROUND_W-1:0] round,
                                           bit [UID_W-1:0] uid, bit [VALUE_BITS-1:0] val);
        plqt_msg_t m;
        m.acceptor_index = acc;
        m.proposal_round = round;
        m.proposer_uid   = uid;
        m.value_tag      = val;
        return m;
    endfunction

    // One request on msg. valid is left high after the handshake so that a
    // zero-gap follow-up never lowers and raises it in the same step; any
    // pause lowers it first.
    task automatic send_request(plqt_msg_t m);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid   <= 1'b1;
        msg_if.payload <= m;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        sb.note_request(m);
    endtask

    // Sender stops until every predicted resolution has been taken.
    task automatic hold_for_resolutions();
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Idle point: drained, plus slack for a last no-result message in flight.
    task automatic settle();
        hold_for_resolutions();
        repeat (10) @(posedge clk);
    endtask

    // Both registers back to back; valid stays high across the pair.
    task automatic program_registers(bit [QUORUM_W-1:0] q, bit [NODE_W-1:0] node);
        bit [CFG_DATA_W-1:0] qdata;
        qdata = CFG_DATA_W'($urandom_range(0, 255));   // upper bits are don't-care for quorum
        qdata[QUORUM_W-1:0] = q;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_QUORUM;
        cfg_if.data  <= qdata;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.set_register(REG_QUORUM, qdata);
        cfg_if.index <= REG_NODE_ID;
        cfg_if.data  <= node;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.set_register(REG_NODE_ID, node);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic. Mostly ballots: one id sent by a random subset of
    // acceptors in random order, with the odd differing value or older round
    // mixed in. Then repeats of the decided value (early path) and noise.
    // Fully random rounds park an acceptor far ahead; only allowed at small
    // quorums where the next decision clears it again.
    task automatic run_traffic(int n_items);
        int               count;
        int               kind;
        int               n;
        int               j;
        int               tmp;
        int               pause_at;
        int               order [NUM_ACCEPTORS];
        bit               paused;
        bit [ROUND_W-1:0] round;
        bit [UID_W-1:0]   uid;
        bit [VALUE_BITS-1:0] val;
        bit [ROUND_W-1:0] r;
        bit [VALUE_BITS-1:0] v;
        count    = 0;
        paused   = 1'b0;
        pause_at = $urandom_range(1, n_items - 1);
        while (count < n_items)
        begin
            if ($urandom_range(0, 99) == 0)
                calm = ~calm;
            if (!paused && count >= pause_at)
            begin
                hold_for_resolutions();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                // well-formed ballot
                round = ballot_base + $urandom_range(0, 2);
                uid   = ($urandom_range(0, 3) != 0) ? UID_W'($urandom_range(0, 3))
                                                    : UID_W'($urandom_range(0, 255));
                val   = value_pool[$urandom_range(0, 3)];
                n     = $urandom_range(1, NUM_ACCEPTORS);
                for (int i = 0; i < NUM_ACCEPTORS; i++)
                    order[i] = i;
                for (int i = NUM_ACCEPTORS - 1; i > 0; i--)
                begin
                    j        = $urandom_range(0, i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < n; i++)
                begin
                    r = round;
                    v = val;
                    tmp = $urandom_range(0, 9);
                    if (tmp == 0)
                        v = value_pool[$urandom_range(0, 3)];   // same id, other value
                    else if (tmp == 1 && r != 0)
                        r = r - 1;                              // out-of-order round
                    send_request(make_msg(ACC_W'(order[i]), r, uid, v));
                    count++;
                end
                ballot_base = ballot_base + $urandom_range(0, 2);
            end
            else if (kind < 80 && sb.decided)
            begin
                // decided value again, at or just above the decided id
                round = sb.decided_id[ID_W-1:UID_W];
                uid   = sb.decided_id[UID_W-1:0];
                if (round != '1 && $urandom_range(0, 1) == 1)
                    round = round + 1;
                send_request(make_msg(ACC_W'($urandom_range(0, NUM_ACCEPTORS - 1)), round,
                                      uid, sb.decided_val));
                count++;
            end
            else
            begin
                // noise
                if (sb.quorum >= 1 && sb.quorum <= 4 && $urandom_range(0, 4) == 0)
                    round = $urandom();
                else
                    round = ballot_base + $urandom_range(0, 4);
                val = ($urandom_range(0, 1) == 1) ? $urandom() : value_pool[$urandom_range(0, 3)];
                send_request(make_msg(ACC_W'($urandom_range(0, NUM_ACCEPTORS - 1)), round,
                                      UID_W'($urandom_range(0, 255)), val));
                count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stalls drawn per resolution, checked at acceptance.
    // ------------------------------------------------------------------
    initial
    begin : res_side
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid)
                @(posedge clk);
            sb.check_result(res_if.payload);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        sb = new();
        msg_if.valid   = 1'b0;
        msg_if.payload = '0;
        res_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = REG_QUORUM;
        cfg_if.data    = '0;
        rst_n          = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, quorum 2, node id all ones
        program_registers(4'd2, 8'hFF);
        send_request(make_msg(3'd0, 32'h0, 8'h00, 32'h0));            // first accept
        send_request(make_msg(3'd0, 32'h0, 8'h00, 32'h0));            // stale, equal id
        send_request(make_msg(3'd1, 32'h0, 8'h00, 32'hFFFF_FFFF));    // quorum, own value
        send_request(make_msg(3'd5, 32'h0, 8'h00, 32'hFFFF_FFFF));    // early, same id
        send_request(make_msg(3'd7, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF)); // early, top id
        send_request(make_msg(3'd7, 32'hFFFF_FFFF, 8'hFF, 32'h1));    // other value: counted
        send_request(make_msg(3'd7, 32'hFFFF_FFFF, 8'hFF, 32'h1));    // stale
        send_request(make_msg(3'd6, 32'hFFFF_FFFF, 8'hFF, 32'h2));    // decision replaced
        send_request(make_msg(3'd3, 32'h0, 8'h00, 32'h2));            // below decided id
        send_request(make_msg(3'd3, 32'h1, 8'h00, 32'h5));            // retain moves, entry freed
        send_request(make_msg(3'd4, 32'h0, 8'h80, 32'h7));
        send_request(make_msg(3'd4, 32'h0, 8'hFF, 32'h7));            // newer by proposer only
        send_request(make_msg(3'd2, 32'h0, 8'h7F, 32'hAAAA_AAAA));
        send_request(make_msg(3'd5, 32'h1, 8'h00, 32'h5555_5555));    // known id, other value
        send_request(make_msg(3'd0, 32'hFFFF_FFFF, 8'hFF, 32'h5555_5555)); // early
        settle();

        // Random phases over several settings; registers written only when idle
        ballot_base = $urandom() >> 1;
        for (int p = 0; p < 10; p++)
        begin
            program_registers(QUORUM_W'(phase_quorum[p]),
                              (p == 1) ? 8'h00 : 8'($urandom_range(0, 255)));
            for (int i = 0; i < 4; i++)
                value_pool[i] = $urandom();
            run_traffic(phase_items[p]);
            settle();
        end

        if (sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin : watchdog
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
